>>> rtl/rme_pkg.sv
// package: widths, cordic constants and shared types for rotation matrix to euler
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;

  localparam int EntryWidth   = 16;
  localparam int AngleWidth   = 16;
  localparam int CordicStages = 16;
  localparam int GuardBits    = 8;
  localparam int ThreshWidth  = 15;

  // datapath: entry plus guard bits plus headroom for cordic growth
  localparam int DataWidth    = EntryWidth + GuardBits + 4;
  // angle accumulator, q.30 radians plus sign and headroom
  localparam int ZWidth       = 34;
  localparam int MagWidth     = 20 + DataWidth;

  localparam logic signed [ZWidth-1:0] PiQ30 = 34'sd3373259426;
  localparam logic [19:0] InvGainQ20 = 20'd636751;
  localparam int AngShift = 33 - AngleWidth;
  localparam logic signed [AngleWidth-1:0] AngLim =
    AngleWidth'((64'd3373259426 + (64'd1 << (AngShift - 1))) >> AngShift);

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [ZWidth-1:0]    ang_t;

  // one vectoring cordic lane as it moves between cells
  typedef struct packed {
    data_t x;
    data_t y;
    ang_t  z;
    logic  zero;
  } lane_t;

  function automatic ang_t atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  atan_q30 = 34'sh03243F6A8;
      5'd1:  atan_q30 = 34'sh01DAC6705;
      5'd2:  atan_q30 = 34'sh00FADBAFC;
      5'd3:  atan_q30 = 34'sh007F56EA6;
      5'd4:  atan_q30 = 34'sh003FEAB76;
      5'd5:  atan_q30 = 34'sh001FFD55B;
      5'd6:  atan_q30 = 34'sh000FFFAAA;
      5'd7:  atan_q30 = 34'sh0007FFF55;
      5'd8:  atan_q30 = 34'sh0003FFFEA;
      5'd9:  atan_q30 = 34'sh0001FFFFD;
      5'd10: atan_q30 = 34'sh0000FFFFF;
      5'd11: atan_q30 = 34'sh00007FFFF;
      5'd12: atan_q30 = 34'sh00003FFFF;
      5'd13: atan_q30 = 34'sh00001FFFF;
      5'd14: atan_q30 = 34'sh00000FFFF;
      5'd15: atan_q30 = 34'sh000007FFF;
      5'd16: atan_q30 = 34'sh000003FFF;
      5'd17: atan_q30 = 34'sh000001FFF;
      5'd18: atan_q30 = 34'sh000000FFF;
      5'd19: atan_q30 = 34'sh0000007FF;
      5'd20: atan_q30 = 34'sh0000003FF;
      5'd21: atan_q30 = 34'sh0000001FF;
      5'd22: atan_q30 = 34'sh0000000FF;
      5'd23: atan_q30 = 34'sh00000007F;
      5'd24: atan_q30 = 34'sh00000003F;
      5'd25: atan_q30 = 34'sh00000001F;
      5'd26: atan_q30 = 34'sh00000000F;
      5'd27: atan_q30 = 34'sh000000008;
      5'd28: atan_q30 = 34'sh000000004;
      5'd29: atan_q30 = 34'sh000000002;
      5'd30: atan_q30 = 34'sh000000001;
      default: atan_q30 = '0;
    endcase
  endfunction

  // pre-rotation by pi for a negative x, zero vector flagged
  function automatic lane_t lane_start(input data_t x, input data_t y);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      l.x = -x;
      l.y = -y;
      l.z = (y < 0) ? -PiQ30 : PiQ30;
    end else begin
      l.x = x;
      l.y = y;
      l.z = '0;
    end
    return l;
  endfunction

  // round half up from q.30, clamp to plus or minus pi; a zero vector gives zero
  function automatic logic signed [AngleWidth-1:0] to_angle(input ang_t z, input logic zero);
    ang_t r;
    ang_t a;
    r = z + (ang_t'(1) <<< (AngShift - 1));
    a = r >>> AngShift;
    if (zero)
      return '0;
    if (a > ang_t'(AngLim))
      return AngLim;
    if (a < -ang_t'(AngLim))
      return -AngLim;
    return a[AngleWidth-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/rotation_matrix_to_euler_top.sv
// top level: two cordic rows in series (yaw and magnitude, then pitch and roll)
// throughput: one request per cycle; the whole pipe advances when the output
// register is free or being taken, so a stalled result holds everything behind it
// reset: synchronous active low rst_n clears valid bits and sets the threshold to 1
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_euler_top
  import rme_pkg::*;
(
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire        [ThreshWidth-1:0]  cfg_singular_threshold,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire signed [EntryWidth-1:0]   in_r_00,
  input  wire signed [EntryWidth-1:0]   in_r_10,
  input  wire signed [EntryWidth-1:0]   in_r_20,
  input  wire signed [EntryWidth-1:0]   in_r_21,
  input  wire signed [EntryWidth-1:0]   in_r_22,
  input  wire signed [EntryWidth-1:0]   in_r_12,
  input  wire signed [EntryWidth-1:0]   in_r_11,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [AngleWidth-1:0]  out_roll,
  output logic signed [AngleWidth-1:0]  out_pitch,
  output logic signed [AngleWidth-1:0]  out_yaw,
  output logic                          out_is_singular
);

  localparam int Lat = 2 * CordicStages + 2;

  logic en;
  logic [Lat-1:0] vld_r;
  logic [ThreshWidth-1:0] thresh_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= ThreshWidth'(1);
    end else if (cfg_we) begin
      thresh_r <= cfg_singular_threshold;
    end
  end

  // pipeline advances whenever the output slot can take data
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  function automatic data_t wid(input logic signed [EntryWidth-1:0] v);
    return data_t'(v) <<< GuardBits;
  endfunction

  // first row: yaw lane; the other entries ride along
  lane_t a_in, a_out;
  data_t r20_d [1:CordicStages];
  data_t r21_d [1:CordicStages];
  data_t r22_d [1:CordicStages];
  data_t r12_d [1:CordicStages];
  data_t r11_d [1:CordicStages];

  assign a_in = lane_start(wid(in_r_00), wid(in_r_10));

  rme_chain u_row_a (.clk(clk), .en(en), .lane_in(a_in), .lane_out(a_out));

  always_ff @(posedge clk) begin
    if (en) begin
      r20_d[1] <= wid(in_r_20);
      r21_d[1] <= wid(in_r_21);
      r22_d[1] <= wid(in_r_22);
      r12_d[1] <= wid(in_r_12);
      r11_d[1] <= wid(in_r_11);
      for (int i = 1; i < CordicStages; i++) begin
        r20_d[i+1] <= r20_d[i];
        r21_d[i+1] <= r21_d[i];
        r22_d[i+1] <= r22_d[i];
        r12_d[i+1] <= r12_d[i];
        r11_d[i+1] <= r11_d[i];
      end
    end
  end

  // magnitude scaling: multiply stage
  logic [MagWidth-1:0] prod_r;
  lane_t a1_r;
  data_t m20_r, m21_r, m22_r, m12_r, m11_r;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= MagWidth'((a_out.x < 0) ? data_t'(0) : a_out.x) * MagWidth'(InvGainQ20);
      a1_r   <= a_out;
      m20_r  <= r20_d[CordicStages];
      m21_r  <= r21_d[CordicStages];
      m22_r  <= r22_d[CordicStages];
      m12_r  <= r12_d[CordicStages];
      m11_r  <= r11_d[CordicStages];
    end
  end

  // round, threshold compare and branch select
  data_t sy;
  logic [MagWidth-1:0] sy_full;
  logic [MagWidth-1:0] sy_ent;
  logic sing;
  assign sy_full = (prod_r + (MagWidth'(1) << 19)) >> 20;
  assign sy      = a1_r.zero ? data_t'(0) : data_t'(sy_full);
  assign sy_ent  = (MagWidth'(sy) + (MagWidth'(1) << (GuardBits - 1))) >> GuardBits;
  assign sing    = sy_ent < MagWidth'(thresh_r);

  lane_t p_in, r_in, p_out, q_out;
  lane_t p_r, q_r;
  logic signed [AngleWidth-1:0] yaw_r;
  logic sing_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= lane_start(sy, -m20_r);
      q_r    <= sing ? lane_start(m11_r, -m12_r) : lane_start(m22_r, m21_r);
      yaw_r  <= sing ? '0 : to_angle(a1_r.z, a1_r.zero);
      sing_r <= sing;
    end
  end
  assign p_in = p_r;
  assign r_in = q_r;

  // second row: pitch and roll lanes side by side
  rme_chain u_row_p (.clk(clk), .en(en), .lane_in(p_in), .lane_out(p_out));
  rme_chain u_row_r (.clk(clk), .en(en), .lane_in(r_in), .lane_out(q_out));

  logic signed [AngleWidth-1:0] yaw_d [1:CordicStages];
  logic sing_d [1:CordicStages];
  always_ff @(posedge clk) begin
    if (en) begin
      yaw_d[1]  <= yaw_r;
      sing_d[1] <= sing_r;
      for (int i = 1; i < CordicStages; i++) begin
        yaw_d[i+1]  <= yaw_d[i];
        sing_d[i+1] <= sing_d[i];
      end
    end
  end

  // output register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_roll        <= to_angle(q_out.z, q_out.zero);
      out_pitch       <= to_angle(p_out.z, p_out.zero);
      out_yaw         <= yaw_d[CordicStages];
      out_is_singular <= sing_d[CordicStages];
    end
  end
  assign out_valid = out_valid_r;

  // checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_yaw) && $stable(out_roll))
    else $error("result changed while stalled");
  a_sing_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_singular |-> out_yaw == '0)
    else $error("singular yaw not zero");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("ready low with empty output");

endmodule
`default_nettype wire

>>> rtl/rme_cell.sv
// cordic cell: one vectoring micro-rotation on one lane, one register stage
`timescale 1ns / 1ps
`default_nettype none
module rme_cell
  import rme_pkg::*;
(
  input  wire        clk,
  input  wire        en,
  input  wire  [4:0] stage,
  input  lane_t      lane_in,
  output lane_t      lane_out
);

  lane_t lane_nxt;
  data_t dx;
  data_t dy;

  // shift-add rotation toward the x axis
  always_comb begin
    lane_nxt = lane_in;
    dx = lane_in.y >>> stage;
    dy = lane_in.x >>> stage;
    if (lane_in.y >= 0) begin
      lane_nxt.x = lane_in.x + dx;
      lane_nxt.y = lane_in.y - dy;
      lane_nxt.z = lane_in.z + atan_q30(stage);
    end else begin
      lane_nxt.x = lane_in.x - dx;
      lane_nxt.y = lane_in.y + dy;
      lane_nxt.z = lane_in.z - atan_q30(stage);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rme_chain.sv
// row of cordic cells for one lane
`timescale 1ns / 1ps
`default_nettype none
module rme_chain
  import rme_pkg::*;
(
  input  wire   clk,
  input  wire   en,
  input  lane_t lane_in,
  output lane_t lane_out
);

  lane_t taps [CordicStages+1];

  assign taps[0] = lane_in;

  // one cell per micro-rotation
  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    rme_cell u_cell (
      .clk      (clk),
      .en       (en),
      .stage    (5'(g)),
      .lane_in  (taps[g]),
      .lane_out (taps[g+1])
    );
  end

  assign lane_out = taps[CordicStages];

endmodule
`default_nettype wire

>>> sim/rotation_matrix_to_euler_top_test.sv
// testbench: rotation matrix to euler angles, checked against a built-in cordic predictor
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_euler_top_test
  import rme_pkg::*;
;

  localparam longint PiFix     = 64'sd3373259426;
  localparam longint InvGain   = 64'sd636751;
  localparam int     Guard     = 8;
  localparam int     Settle    = 60;
  localparam int     IdleLimit = 5000;

  typedef struct {
    logic signed [EntryWidth-1:0] r00, r10, r20, r21, r22, r12, r11;
  } matrix_t;

  typedef struct {
    logic signed [AngleWidth-1:0] roll, pitch, yaw;
    logic                         sing;
  } euler_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ThreshWidth-1:0] cfg_singular_threshold = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [EntryWidth-1:0] in_r_00 = '0, in_r_10 = '0, in_r_20 = '0, in_r_21 = '0;
  logic signed [EntryWidth-1:0] in_r_22 = '0, in_r_12 = '0, in_r_11 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [AngleWidth-1:0] out_roll, out_pitch, out_yaw;
  logic out_is_singular;

  matrix_t matrix_q[$];
  euler_t  angles_q[$];
  matrix_t cur;
  logic [ThreshWidth-1:0] thresh = 1;
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int cycle = 0;

  rotation_matrix_to_euler_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_singular_threshold(cfg_singular_threshold),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_r_00(in_r_00), .in_r_10(in_r_10), .in_r_20(in_r_20), .in_r_21(in_r_21),
    .in_r_22(in_r_22), .in_r_12(in_r_12), .in_r_11(in_r_11),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll(out_roll), .out_pitch(out_pitch), .out_yaw(out_yaw),
    .out_is_singular(out_is_singular)
  );

  always #5 clk = ~clk;

  function automatic longint atan_table(input int i);
    longint t[32] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
      'h00000001, 'h00000000};
    return t[i];
  endfunction

  // vectoring cordic: angle of (x, y) in q.30, magnitude scaled back by the gain
  function automatic longint vector_angle(input longint x0, input longint y0,
                                          output longint mag);
    longint x, y, z, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    mag = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y < 0) ? -PiFix : PiFix;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicStages && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_table(i));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_table(i));
      end
    end
    if (x < 0) x = 0;
    mag = (x * InvGain + (64'sd1 <<< 19)) >>> 20;
    return z;
  endfunction

  // round half up from q.30 to the output format and clamp to plus or minus pi
  function automatic logic signed [AngleWidth-1:0] angle_out(input longint z);
    int sh;
    longint lim, a;
    sh = 33 - AngleWidth;
    lim = (PiFix + (64'sd1 <<< (sh - 1))) >>> sh;
    a = (z + (64'sd1 <<< (sh - 1))) >>> sh;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a[AngleWidth-1:0];
  endfunction

  function automatic euler_t predict_euler(input matrix_t m, input logic [ThreshWidth-1:0] th);
    euler_t e;
    longint sy, unused, yaw, pitch, roll;
    longint sy_entry;
    yaw = vector_angle(longint'(m.r00) <<< Guard, longint'(m.r10) <<< Guard, sy);
    sy_entry = (sy + (64'sd1 <<< (Guard - 1))) >>> Guard;
    e.sing = sy_entry < longint'(th);
    pitch = vector_angle(sy, -(longint'(m.r20) <<< Guard), unused);
    if (!e.sing)
      roll = vector_angle(longint'(m.r22) <<< Guard, longint'(m.r21) <<< Guard, unused);
    else begin
      roll = vector_angle(longint'(m.r11) <<< Guard, -(longint'(m.r12) <<< Guard), unused);
      yaw = 0;
    end
    e.roll = angle_out(roll);
    e.pitch = angle_out(pitch);
    e.yaw = angle_out(yaw);
    return e;
  endfunction

  function automatic logic signed [EntryWidth-1:0] to_entry(input real v);
    real s;
    s = v * 16384.0;
    if (s > 32767.0) s = 32767.0;
    if (s < -32768.0) s = -32768.0;
    return EntryWidth'($rtoi(s));
  endfunction

  // proper rotation matrix from roll, pitch, yaw
  function automatic matrix_t rotation(input real r, input real p, input real y);
    matrix_t m;
    m.r00 = to_entry($cos(y) * $cos(p));
    m.r10 = to_entry($sin(y) * $cos(p));
    m.r20 = to_entry(-$sin(p));
    m.r21 = to_entry($cos(p) * $sin(r));
    m.r22 = to_entry($cos(p) * $cos(r));
    m.r12 = to_entry($sin(y) * $sin(p) * $cos(r) - $cos(y) * $sin(r));
    m.r11 = to_entry($sin(y) * $sin(p) * $sin(r) + $cos(y) * $cos(r));
    return m;
  endfunction

  function automatic matrix_t noise_matrix();
    matrix_t m;
    m.r00 = EntryWidth'($urandom); m.r10 = EntryWidth'($urandom);
    m.r20 = EntryWidth'($urandom); m.r21 = EntryWidth'($urandom);
    m.r22 = EntryWidth'($urandom); m.r12 = EntryWidth'($urandom);
    m.r11 = EntryWidth'($urandom);
    return m;
  endfunction

  function automatic matrix_t uniform_matrix(input logic signed [EntryWidth-1:0] v);
    matrix_t m;
    m = '{v, v, v, v, v, v, v};
    return m;
  endfunction

  function automatic real rand_angle(input real span);
    return ($itor($urandom_range(0, 20000)) / 10000.0 - 1.0) * span;
  endfunction

  // append one request to the pending list
  task automatic enqueue(input matrix_t m);
    matrix_q.insert(matrix_q.size(), m);
  endtask

  // mostly well-formed rotations, some near gimbal lock, some noise
  task automatic push_random(input int n);
    matrix_t m;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5)
        m = rotation(rand_angle(3.1416), rand_angle(1.5708), rand_angle(3.1416));
      else if (kind < 7)
        m = rotation(rand_angle(3.1416), (kind == 5 ? 1.0 : -1.0) *
                     (1.5708 - rand_angle(0.02)), rand_angle(3.1416));
      else
        m = noise_matrix();
      enqueue(m);
    end
  endtask

  task automatic push_directed();
    matrix_t m;
    enqueue(rotation(0.0, 0.0, 0.0));
    enqueue(uniform_matrix(16'sh7FFF));
    enqueue(uniform_matrix(-16'sh8000));
    enqueue(uniform_matrix(16'sh0000));
    // zero r00 and r10: singular even at the lowest nonzero threshold
    m = rotation(0.3, 1.5708, 0.0);
    m.r00 = 0; m.r10 = 0;
    enqueue(m);
    // negative x with y zero and y negative
    m = rotation(0.0, 0.0, 3.14159);
    m.r10 = 0; m.r21 = 0; m.r22 = -16384;
    enqueue(m);
    m.r10 = -1; m.r21 = -1;
    enqueue(m);
    m = rotation(0.0, 0.0, 0.0);
    m.r00 = -16'sh8000; m.r10 = 16'sh7FFF; m.r20 = 16'sh7FFF;
    enqueue(m);
    m.r20 = -16'sh8000; m.r00 = 16'sh7FFF; m.r10 = -16'sh8000;
    enqueue(m);
    enqueue(rotation(1.0, 1.5708, 0.5));
    enqueue(rotation(-1.0, -1.5708, -0.5));
    enqueue(rotation(3.14159, 0.0, -3.14159));
    enqueue(rotation(-3.14159, 0.7, 3.14159));
    for (int i = 0; i < 8; i++)
      enqueue(noise_matrix());
  endtask

  // wait until every request is taken and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (matrix_q.size() != 0 || in_valid || angles_q.size() != 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [ThreshWidth-1:0] v);
    cfg_we <= 1'b1;
    cfg_singular_threshold <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh = v;
    @(posedge clk);
  endtask

  // stimulus and configuration phases
  initial begin
    logic [ThreshWidth-1:0] settings[6];
    settings = '{15'd0, 15'd32767, 15'd16384, 15'd200, 15'd1, 15'd3000};
    settings[5] = ThreshWidth'($urandom_range(0, 32767));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    push_directed();
    push_random(60);
    drain();
    foreach (settings[k]) begin
      write_threshold(settings[k]);
      if (k == 0 || k == 3) push_directed();
      push_random(70);
      drain();
    end
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // request driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || matrix_q.size() == 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        cur = matrix_q.pop_front();
        in_r_00 <= cur.r00; in_r_10 <= cur.r10; in_r_20 <= cur.r20;
        in_r_21 <= cur.r21; in_r_22 <= cur.r22; in_r_12 <= cur.r12;
        in_r_11 <= cur.r11;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // result receiver: stall pattern rotates through four modes
  always @(posedge clk) begin
    cycle <= cycle + 1;
    case ((cycle / 300) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (cycle % 5 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // monitor: predict on each request, compare each result, watchdog
  always @(posedge clk) begin
    euler_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        angles_q.insert(angles_q.size(),
                        predict_euler('{in_r_00, in_r_10, in_r_20, in_r_21,
                                        in_r_22, in_r_12, in_r_11}, thresh));
      if (out_valid && out_ready) begin
        if (angles_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          want = angles_q.pop_front();
          if (out_roll !== want.roll || out_pitch !== want.pitch ||
              out_yaw !== want.yaw || out_is_singular !== want.sing) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at %0t: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d sing %0b/%0b",
                       $realtime, out_roll, want.roll, out_pitch, want.pitch,
                       out_yaw, want.yaw, out_is_singular, want.sing);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/rme_pkg.sv
rtl/rme_cell.sv
rtl/rme_chain.sv
rtl/rotation_matrix_to_euler_top.sv
sim/rotation_matrix_to_euler_top_test.sv
